// ----- hw/rtl/qpsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qpsc_pkg;

    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int SUM_WIDTH_DEF      = 32;
    localparam int GAIN_FRAC_BITS_DEF = 8;

    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 16;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_PROP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_INTEG_GAIN   = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_STEP  = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_LIMIT = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DRIVE_LIMIT  = 3'd5;

    localparam logic [15:0] PROP_GAIN_RST    = 16'd192;
    localparam logic [15:0] INTEG_GAIN_RST   = 16'd64;
    localparam logic [15:0] DERIV_GAIN_RST   = 16'd64;
    localparam logic [7:0]  TARGET_STEP_RST  = 8'd2;
    localparam logic [14:0] TARGET_LIMIT_RST = 15'd500;
    localparam logic [11:0] DRIVE_LIMIT_RST  = 12'd1024;

    localparam logic [2:0] MODE_EDGE_A      = 3'd0;
    localparam logic [2:0] MODE_EDGE_B      = 3'd1;
    localparam logic [2:0] MODE_TARGET_UP   = 3'd2;
    localparam logic [2:0] MODE_TARGET_DOWN = 3'd3;
    localparam logic [2:0] MODE_TICK        = 3'd4;

    // gain-weighted partial sums saturate at a magnitude of 2**SUM_CAP_BIT
    localparam int SUM_CAP_BIT = 62;

endpackage

`default_nettype wire

// ----- hw/rtl/quadrature_pid_speed_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Quadrature encoder speed controller with a discrete PID loop. One event item is
// accepted per clock unless o_stall is high: encoder edges and target steps update
// internal state at the accepting edge and return no result; a control tick returns
// one result item through three registered stages (error/integral/derivative stage,
// gain multiplier stage, sum/clamp stage into the output register). Ticks queue in
// those three stages, so the input stalls only when three ticks wait behind a
// stalled output. Configuration writes take effect at the next clock edge.
module quadrature_pid_speed_controller #(
    parameter int COUNT_WIDTH    = qpsc_pkg::COUNT_WIDTH_DEF,
    parameter int SUM_WIDTH      = qpsc_pkg::SUM_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = qpsc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [qpsc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  wire logic [qpsc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [2:0]                          i_mode,
    input  wire logic                                i_level,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [11:0]                              o_drive_magnitude,
    output logic                                     o_reverse,
    output logic signed [15:0]                       o_target_out,
    output logic signed [15:0]                       o_count_out,
    output logic signed [16:0]                       o_error_out,
    output logic signed [31:0]                       o_integral_out,
    output logic signed [17:0]                       o_derivative_out
);

    localparam int CW  = COUNT_WIDTH;
    localparam int IW  = SUM_WIDTH;
    localparam int EW  = ((CW > 16) ? CW : 16) + 1;
    localparam int DW  = EW + 1;
    localparam int SW2 = ((IW > EW) ? IW : EW) + 1;
    localparam int PW  = EW + 17;
    localparam int DPW = DW + 17;
    localparam int IPW = IW + 17;
    localparam int AW  = ((IPW > 64) ? IPW : 64) + 2;

    localparam logic signed [CW-1:0]  CNT_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0]  CNT_LO = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [SW2-1:0] SUM_HI = {{(SW2-IW+1){1'b0}}, {(IW-1){1'b1}}};
    localparam logic signed [SW2-1:0] SUM_LO = ~SUM_HI;
    localparam logic signed [AW-1:0]  CAP_HI =
        {{(AW-qpsc_pkg::SUM_CAP_BIT-1){1'b0}}, 1'b1, {qpsc_pkg::SUM_CAP_BIT{1'b0}}};
    localparam logic signed [AW-1:0]  CAP_LO = -CAP_HI;
    localparam logic signed [AW-1:0]  RND    =
        {{(AW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

    // configuration
    logic [15:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [7:0]  r_target_step;
    logic [14:0] r_target_limit;
    logic [11:0] r_drive_limit;

    // controller state
    logic                 r_last_a, r_last_b;
    logic signed [CW-1:0] r_count;
    logic signed [15:0]   r_target;
    logic signed [IW-1:0] r_sum;
    logic signed [EW-1:0] r_prev_err;

    // pipeline
    logic                 r_p_valid, r_m_valid, r_o_valid;
    logic signed [15:0]   r_p_target, r_m_target;
    logic signed [CW-1:0] r_p_count, r_m_count;
    logic signed [EW-1:0] r_p_err, r_m_err;
    logic signed [IW-1:0] r_p_integ, r_m_integ;
    logic signed [DW-1:0] r_p_deriv, r_m_deriv;
    logic signed [PW-1:0]  r_m_pprod;
    logic signed [DPW-1:0] r_m_dprod;
    logic signed [IPW-1:0] r_m_iprod;

    logic [11:0]        r_o_mag;
    logic               r_o_rev;
    logic signed [15:0] r_o_target, r_o_count;
    logic signed [16:0] r_o_err;
    logic signed [31:0] r_o_integ;
    logic signed [17:0] r_o_deriv;

    logic o_free, m_free, in_acc, tick_acc;

    assign o_free   = !r_o_valid || !i_stall;
    assign m_free   = !r_m_valid || o_free;
    assign o_stall  = r_p_valid && !m_free;
    assign in_acc   = i_valid && !o_stall;
    assign tick_acc = in_acc && (i_mode == qpsc_pkg::MODE_TICK);

    // tick front end: error, saturating integral, derivative
    logic signed [EW-1:0]  err;
    logic signed [SW2-1:0] sum_raw;
    logic signed [IW-1:0]  integ;
    logic signed [DW-1:0]  deriv;

    always_comb begin
        err = {{(EW-16){r_target[15]}}, r_target} - {{(EW-CW){r_count[CW-1]}}, r_count};
        sum_raw = {{(SW2-IW){r_sum[IW-1]}}, r_sum} + {{(SW2-EW){err[EW-1]}}, err};
        if (sum_raw > SUM_HI) begin
            integ = SUM_HI[IW-1:0];
        end else if (sum_raw < SUM_LO) begin
            integ = SUM_LO[IW-1:0];
        end else begin
            integ = sum_raw[IW-1:0];
        end
        deriv = {err[EW-1], err} - {r_prev_err[EW-1], r_prev_err};
    end

    // target step with clamp
    logic signed [17:0] t_step, t_lim, n_target_wide;

    always_comb begin
        t_lim = {3'b000, r_target_limit};
        if (i_mode == qpsc_pkg::MODE_TARGET_UP) begin
            t_step = {{2{r_target[15]}}, r_target} + {10'd0, r_target_step};
        end else begin
            t_step = {{2{r_target[15]}}, r_target} - {10'd0, r_target_step};
        end
        if (t_step > t_lim) begin
            n_target_wide = t_lim;
        end else if (t_step < -t_lim) begin
            n_target_wide = -t_lim;
        end else begin
            n_target_wide = t_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= qpsc_pkg::PROP_GAIN_RST;
            r_integ_gain   <= qpsc_pkg::INTEG_GAIN_RST;
            r_deriv_gain   <= qpsc_pkg::DERIV_GAIN_RST;
            r_target_step  <= qpsc_pkg::TARGET_STEP_RST;
            r_target_limit <= qpsc_pkg::TARGET_LIMIT_RST;
            r_drive_limit  <= qpsc_pkg::DRIVE_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qpsc_pkg::REG_PROP_GAIN:    r_prop_gain    <= i_cfg_data;
                qpsc_pkg::REG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data;
                qpsc_pkg::REG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data;
                qpsc_pkg::REG_TARGET_STEP:  r_target_step  <= i_cfg_data[7:0];
                qpsc_pkg::REG_TARGET_LIMIT: r_target_limit <= i_cfg_data[14:0];
                qpsc_pkg::REG_DRIVE_LIMIT:  r_drive_limit  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a   <= 1'b0;
            r_last_b   <= 1'b0;
            r_count    <= '0;
            r_target   <= '0;
            r_sum      <= '0;
            r_prev_err <= '0;
        end else if (in_acc) begin
            case (i_mode)
                qpsc_pkg::MODE_EDGE_A: begin
                    if (i_level == r_last_b && r_count != CNT_HI) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_last_a <= i_level;
                end
                qpsc_pkg::MODE_EDGE_B: begin
                    if (i_level == r_last_a && r_count != CNT_LO) begin
                        r_count <= r_count - CW'(1);
                    end
                    r_last_b <= i_level;
                end
                qpsc_pkg::MODE_TARGET_UP, qpsc_pkg::MODE_TARGET_DOWN: begin
                    r_target <= n_target_wide[15:0];
                end
                qpsc_pkg::MODE_TICK: begin
                    r_sum      <= integ;
                    r_prev_err <= err;
                    r_count    <= '0;
                end
                default: ;
            endcase
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (tick_acc) begin
                r_p_valid <= 1'b1;
            end else if (m_free) begin
                r_p_valid <= 1'b0;
            end
            if (m_free) begin
                r_m_valid <= r_p_valid;
            end
            if (o_free) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_p_target <= r_target;
            r_p_count  <= r_count;
            r_p_err    <= err;
            r_p_integ  <= integ;
            r_p_deriv  <= deriv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_free && r_p_valid) begin
            r_m_target <= r_p_target;
            r_m_count  <= r_p_count;
            r_m_err    <= r_p_err;
            r_m_integ  <= r_p_integ;
            r_m_deriv  <= r_p_deriv;
            r_m_pprod  <= $signed({{(PW-16){1'b0}}, r_prop_gain})
                        * $signed({{(PW-EW){r_p_err[EW-1]}}, r_p_err});
            r_m_dprod  <= $signed({{(DPW-16){1'b0}}, r_deriv_gain})
                        * $signed({{(DPW-DW){r_p_deriv[DW-1]}}, r_p_deriv});
            r_m_iprod  <= $signed({{(IPW-16){1'b0}}, r_integ_gain})
                        * $signed({{(IPW-IW){r_p_integ[IW-1]}}, r_p_integ});
        end
    end

    // weighted sum, truncation toward zero, drive clamp
    logic signed [AW-1:0] acc_pd, acc_pd_c, acc_i, acc_i_c, acc, quo, drv, dl;
    logic signed [63:0]   cnt64, err64, int64, der64;

    always_comb begin
        acc_pd = {{(AW-PW){r_m_pprod[PW-1]}}, r_m_pprod}
               + {{(AW-DPW){r_m_dprod[DPW-1]}}, r_m_dprod};
        acc_i  = {{(AW-IPW){r_m_iprod[IPW-1]}}, r_m_iprod};
        if (acc_pd > CAP_HI) begin
            acc_pd_c = CAP_HI;
        end else if (acc_pd < CAP_LO) begin
            acc_pd_c = CAP_LO;
        end else begin
            acc_pd_c = acc_pd;
        end
        if (acc_i > CAP_HI) begin
            acc_i_c = CAP_HI;
        end else if (acc_i < CAP_LO) begin
            acc_i_c = CAP_LO;
        end else begin
            acc_i_c = acc_i;
        end
        acc = acc_pd_c + acc_i_c;
        // bias negatives so the arithmetic shift rounds toward zero
        if (acc[AW-1]) begin
            quo = (acc + RND) >>> GAIN_FRAC_BITS;
        end else begin
            quo = acc >>> GAIN_FRAC_BITS;
        end
        dl = {{(AW-12){1'b0}}, r_drive_limit};
        if (quo > dl) begin
            drv = dl;
        end else if (quo < -dl) begin
            drv = -dl;
        end else begin
            drv = quo;
        end
        cnt64 = {{(64-CW){r_m_count[CW-1]}}, r_m_count};
        err64 = {{(64-EW){r_m_err[EW-1]}}, r_m_err};
        int64 = {{(64-IW){r_m_integ[IW-1]}}, r_m_integ};
        der64 = {{(64-DW){r_m_deriv[DW-1]}}, r_m_deriv};
    end

    logic signed [AW-1:0] drv_abs;
    assign drv_abs = drv[AW-1] ? -drv : drv;

    always_ff @(posedge i_clk) begin
        if (o_free && r_m_valid) begin
            r_o_mag    <= drv_abs[11:0];
            r_o_rev    <= drv[AW-1];
            r_o_target <= r_m_target;
            r_o_count  <= cnt64[15:0];
            r_o_err    <= err64[16:0];
            r_o_integ  <= int64[31:0];
            r_o_deriv  <= der64[17:0];
        end
    end

    assign o_valid           = r_o_valid;
    assign o_drive_magnitude = r_o_mag;
    assign o_reverse         = r_o_rev;
    assign o_target_out      = r_o_target;
    assign o_count_out       = r_o_count;
    assign o_error_out       = r_o_err;
    assign o_integral_out    = r_o_integ;
    assign o_derivative_out  = r_o_deriv;

`ifndef SYNTHESIS
    a_tick_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> (r_count == '0))
        else $error("edge count not cleared after tick");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_p_valid && r_m_valid && r_o_valid && i_stall))
        else $error("input stalled with room in pipeline");

    a_reverse_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reverse) |-> (o_drive_magnitude != 12'd0))
        else $error("reverse set with zero drive");

    a_drive_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_free && r_m_valid) |=> (o_drive_magnitude <= $past(r_drive_limit)))
        else $error("drive magnitude above limit");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/pid_checker.sv -----
`timescale 1ns / 1ps

module pid_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [qpsc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  wire logic [qpsc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  wire logic                                i_in_valid,
    input  wire logic                                i_in_stall,
    input  wire logic [2:0]                          i_mode,
    input  wire logic                                i_level,
    input  wire logic                                i_res_valid,
    input  wire logic                                i_res_stall,
    input  wire logic [11:0]                         i_drive_magnitude,
    input  wire logic                                i_reverse,
    input  wire logic signed [15:0]                  i_target_out,
    input  wire logic signed [15:0]                  i_count_out,
    input  wire logic signed [16:0]                  i_error_out,
    input  wire logic signed [31:0]                  i_integral_out,
    input  wire logic signed [17:0]                  i_derivative_out,
    output int                                       o_mismatches,
    output int                                       o_pending,
    output int                                       o_results
);

    localparam longint COUNT_MAX   = (longint'(1) << (qpsc_pkg::COUNT_WIDTH_DEF - 1)) - 1;
    localparam longint SUM_MAX     = (longint'(1) << (qpsc_pkg::SUM_WIDTH_DEF - 1)) - 1;
    localparam longint PRODUCT_CAP = longint'(1) << qpsc_pkg::SUM_CAP_BIT;
    localparam longint GAIN_ONE    = longint'(1) << qpsc_pkg::GAIN_FRAC_BITS_DEF;

    typedef struct {
        logic [11:0]        drive_magnitude;
        logic               reverse;
        logic signed [15:0] target_out;
        logic signed [15:0] count_out;
        logic signed [16:0] error_out;
        logic signed [31:0] integral_out;
        logic signed [17:0] derivative_out;
    } tick_result_t;

    tick_result_t tick_queue [$];

    longint kp, ki, kd, step_size, target_lim, drive_lim;
    logic   seen_a, seen_b;
    longint edge_cnt, target_pos, err_sum, last_err;

    function automatic longint sat(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin : track
        tick_result_t want, got;
        longint err, integ, deriv, acc, iterm, drive;
        if (!i_rst_n) begin
            kp         = longint'(qpsc_pkg::PROP_GAIN_RST);
            ki         = longint'(qpsc_pkg::INTEG_GAIN_RST);
            kd         = longint'(qpsc_pkg::DERIV_GAIN_RST);
            step_size  = longint'(qpsc_pkg::TARGET_STEP_RST);
            target_lim = longint'(qpsc_pkg::TARGET_LIMIT_RST);
            drive_lim  = longint'(qpsc_pkg::DRIVE_LIMIT_RST);
            seen_a     = 1'b0;
            seen_b     = 1'b0;
            edge_cnt   = 0;
            target_pos = 0;
            err_sum    = 0;
            last_err   = 0;
            tick_queue.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                case (i_mode)
                    qpsc_pkg::MODE_EDGE_A: begin
                        if (i_level == seen_b && edge_cnt < COUNT_MAX)
                            edge_cnt++;
                        seen_a = i_level;
                    end
                    qpsc_pkg::MODE_EDGE_B: begin
                        if (i_level == seen_a && edge_cnt > -COUNT_MAX - 1)
                            edge_cnt--;
                        seen_b = i_level;
                    end
                    qpsc_pkg::MODE_TARGET_UP: begin
                        target_pos = sat(target_pos + step_size, -target_lim, target_lim);
                    end
                    qpsc_pkg::MODE_TARGET_DOWN: begin
                        target_pos = sat(target_pos - step_size, -target_lim, target_lim);
                    end
                    qpsc_pkg::MODE_TICK: begin
                        err   = target_pos - edge_cnt;
                        integ = sat(err_sum + err, -SUM_MAX - 1, SUM_MAX);
                        deriv = err - last_err;
                        acc   = sat(kp * err + kd * deriv, -PRODUCT_CAP, PRODUCT_CAP);
                        iterm = sat(ki * integ, -PRODUCT_CAP, PRODUCT_CAP);
                        // signed division truncates toward zero
                        drive = sat((acc + iterm) / GAIN_ONE, -drive_lim, drive_lim);
                        want.drive_magnitude = 12'((drive < 0) ? -drive : drive);
                        want.reverse         = (drive < 0);
                        want.target_out      = 16'(target_pos);
                        want.count_out       = 16'(edge_cnt);
                        want.error_out       = 17'(err);
                        want.integral_out    = 32'(integ);
                        want.derivative_out  = 18'(deriv);
                        tick_queue.push_back(want);
                        err_sum  = integ;
                        last_err = err;
                        edge_cnt = 0;
                    end
                    default: begin
                    end
                endcase
            end

            if (i_res_valid && !i_res_stall) begin
                got = '{i_drive_magnitude, i_reverse, i_target_out, i_count_out,
                        i_error_out, i_integral_out, i_derivative_out};
                o_results++;
                if (tick_queue.size() == 0) begin
                    report_mismatch("result item with no tick waiting");
                end else begin
                    want = tick_queue.pop_front();
                    if (got.drive_magnitude !== want.drive_magnitude)
                        report_mismatch($sformatf("drive_magnitude %0d, predicted %0d",
                            got.drive_magnitude, want.drive_magnitude));
                    if (got.reverse !== want.reverse)
                        report_mismatch($sformatf("reverse %0b, predicted %0b",
                            got.reverse, want.reverse));
                    if (got.target_out !== want.target_out)
                        report_mismatch($sformatf("target_out %0d, predicted %0d",
                            got.target_out, want.target_out));
                    if (got.count_out !== want.count_out)
                        report_mismatch($sformatf("count_out %0d, predicted %0d",
                            got.count_out, want.count_out));
                    if (got.error_out !== want.error_out)
                        report_mismatch($sformatf("error_out %0d, predicted %0d",
                            got.error_out, want.error_out));
                    if (got.integral_out !== want.integral_out)
                        report_mismatch($sformatf("integral_out %0d, predicted %0d",
                            got.integral_out, want.integral_out));
                    if (got.derivative_out !== want.derivative_out)
                        report_mismatch($sformatf("derivative_out %0d, predicted %0d",
                            got.derivative_out, want.derivative_out));
                end
            end

            // a write lands after any item taken on the same edge
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qpsc_pkg::REG_PROP_GAIN:    kp         = longint'(i_cfg_data);
                    qpsc_pkg::REG_INTEG_GAIN:   ki         = longint'(i_cfg_data);
                    qpsc_pkg::REG_DERIV_GAIN:   kd         = longint'(i_cfg_data);
                    qpsc_pkg::REG_TARGET_STEP:  step_size  = longint'(i_cfg_data[7:0]);
                    qpsc_pkg::REG_TARGET_LIMIT: target_lim = longint'(i_cfg_data[14:0]);
                    qpsc_pkg::REG_DRIVE_LIMIT:  drive_lim  = longint'(i_cfg_data[11:0]);
                    default: begin
                    end
                endcase
            end
        end
        o_pending = tick_queue.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int PIPE_DEPTH    = 3;
    localparam int CYCLE_LIMIT   = 250_000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 300;
    localparam int SPANS [3]     = '{0, 3, 13};

    logic                                i_clk;
    logic                                i_rst_n    = 1'b0;
    logic                                i_cfg_we   = 1'b0;
    logic [qpsc_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_idx  = qpsc_pkg::REG_PROP_GAIN;
    logic [qpsc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data = '0;
    logic                                i_valid    = 1'b0;
    logic                                o_stall;
    logic [2:0]                          i_mode     = qpsc_pkg::MODE_EDGE_A;
    logic                                i_level    = 1'b0;
    logic                                o_valid;
    logic                                i_stall    = 1'b0;
    logic [11:0]                         o_drive_magnitude;
    logic                                o_reverse;
    logic signed [15:0]                  o_target_out;
    logic signed [15:0]                  o_count_out;
    logic signed [16:0]                  o_error_out;
    logic signed [31:0]                  o_integral_out;
    logic signed [17:0]                  o_derivative_out;

    int   mismatches;
    int   pending;
    int   results;
    logic in_taken    = 1'b0;
    logic out_taken   = 1'b0;
    int   stall_left  = 0;
    int   gap_max     = 0;
    int   stall_max   = 0;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   settings    = 0;
    logic pin_a       = 1'b0;
    logic pin_b       = 1'b0;

    quadrature_pid_speed_controller DUT (.*);

    pid_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_mode           (i_mode),
        .i_level          (i_level),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_drive_magnitude(o_drive_magnitude),
        .i_reverse        (o_reverse),
        .i_target_out     (o_target_out),
        .i_count_out      (o_count_out),
        .i_error_out      (o_error_out),
        .i_integral_out   (o_integral_out),
        .i_derivative_out (o_derivative_out),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_results        (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        in_taken  <= i_valid && !o_stall;
        out_taken <= o_valid && !i_stall;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("no progress after %0d cycles", cycle_count);
            $display("FAIL quadrature_pid_speed_controller");
            $finish;
        end
    end

    function automatic int wait_draw(input int span);
        return (span == 0) ? 0 : int'($urandom_range(0, span));
    endfunction

    // receiver: a random hold-off after each result, and now and then with none pending
    always @(negedge i_clk) begin
        if (out_taken)
            stall_left = wait_draw(stall_max);
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (stall_max > 0 && $urandom_range(0, 15) == 0)
            stall_left = wait_draw(stall_max);
        i_stall <= (stall_left > 0);
    end

    task automatic send_item(input logic [2:0] mode, input logic lvl);
        int gap;
        gap = wait_draw(gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_level <= lvl;
        do @(negedge i_clk); while (!in_taken);
        if (mode == qpsc_pkg::MODE_EDGE_A) pin_a = lvl;
        if (mode == qpsc_pkg::MODE_EDGE_B) pin_b = lvl;
        if (mode <= qpsc_pkg::MODE_TICK) items_sent++;
    endtask

    // quadrature steps; forward is the direction that counts up
    task automatic turn_encoder(input bit forward, input int steps);
        repeat (steps) begin
            if ((pin_a == pin_b) == forward)
                send_item(qpsc_pkg::MODE_EDGE_B, !pin_b);
            else
                send_item(qpsc_pkg::MODE_EDGE_A, !pin_a);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    task automatic program_regs(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] kd, input logic [15:0] stp,
                                input logic [15:0] tlim, input logic [15:0] dlim);
        logic [qpsc_pkg::CFG_IDX_WIDTH-1:0] idx [6];
        logic [15:0]                        val [6];
        idx = '{qpsc_pkg::REG_PROP_GAIN, qpsc_pkg::REG_INTEG_GAIN,
                qpsc_pkg::REG_DERIV_GAIN, qpsc_pkg::REG_TARGET_STEP,
                qpsc_pkg::REG_TARGET_LIMIT, qpsc_pkg::REG_DRIVE_LIMIT};
        val = '{kp, ki, kd, stp, tlim, dlim};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [15:0] some_gain();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    endfunction

    task automatic random_phase(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 7) == 0) begin
                gap_max   = SPANS[$urandom_range(0, 2)];
                stall_max = SPANS[$urandom_range(0, 2)];
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: turn_encoder(1'($urandom_range(0, 1)), $urandom_range(1, 40));
                5: repeat ($urandom_range(1, 6))
                    send_item(($urandom_range(0, 1) == 1) ? qpsc_pkg::MODE_TARGET_UP
                                                          : qpsc_pkg::MODE_TARGET_DOWN,
                              1'($urandom_range(0, 1)));
                // tick bursts fill the pipeline behind a stalled output
                6: repeat ($urandom_range(1, 5))
                    send_item(qpsc_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
                7, 8: send_item(qpsc_pkg::MODE_TICK, 1'($urandom_range(0, 1)));
                default: repeat ($urandom_range(1, 5))
                    send_item(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            endcase
        end
    endtask

    initial begin : stimulus
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero tick, counting both ways, unused modes, negative target
        send_item(qpsc_pkg::MODE_TICK, 1'b1);
        repeat (3) send_item(qpsc_pkg::MODE_TARGET_UP, 1'b0);
        send_item(qpsc_pkg::MODE_EDGE_A, 1'b0);
        send_item(qpsc_pkg::MODE_EDGE_A, 1'b1);
        send_item(qpsc_pkg::MODE_EDGE_B, 1'b1);
        send_item(qpsc_pkg::MODE_EDGE_B, 1'b0);
        send_item(qpsc_pkg::MODE_EDGE_A, 1'b0);
        send_item(3'd5, 1'b1);
        send_item(3'd6, 1'b1);
        send_item(3'd7, 1'b1);
        send_item(qpsc_pkg::MODE_TICK, 1'b0);
        repeat (4) send_item(qpsc_pkg::MODE_TARGET_DOWN, 1'b1);
        send_item(qpsc_pkg::MODE_EDGE_B, 1'b0);
        send_item(qpsc_pkg::MODE_TICK, 1'b0);
        send_item(qpsc_pkg::MODE_TICK, 1'b1);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                program_regs('1, '1, '1, '1, '1, '1);
            else if (p == 1)
                program_regs('0, '0, '0, '0, '0, '0);
            else
                program_regs(some_gain(), some_gain(), some_gain(), 16'($urandom),
                             {1'($urandom_range(0, 1)), 15'($urandom_range(0, 3000))},
                             16'($urandom));
            gap_max   = SPANS[$urandom_range(0, 2)];
            stall_max = SPANS[$urandom_range(0, 2)];
            random_phase(PHASE_ITEMS);
            settle();
        end

        $display("covered %0d event items and %0d tick results over %0d register settings",
                 items_sent, results, settings);
        $display("settings ranged from all zeros to full scale, with random gaps and stalls");
        if (mismatches == 0 && pending == 0)
            $display("PASS quadrature_pid_speed_controller");
        else
            $display("FAIL quadrature_pid_speed_controller");
        $finish;
    end

endmodule

// ----- quadrature_pid_speed_controller.f -----
hw/rtl/qpsc_pkg.sv
hw/rtl/quadrature_pid_speed_controller.sv
tb/sv/pid_checker.sv
tb/sv/testbench.sv
